// ----- rtl/rcs_pkg.sv -----
// Shared widths, stage types and status codes for the root-curve coefficient solver.
// Used by every module of the block; no dependencies of its own.
`default_nettype none
package rcs_pkg;

	// Output format and input field width
	localparam int FRAC_BITS = 16;
	localparam int INT_BITS  = 7;
	localparam int IN_W      = 16;
	localparam int COEF_W    = 24;

	// Internal fixed point: roots and differences carry IFRAC fraction bits, squares and products 2*IFRAC, cubes 3*IFRAC
	localparam int IFRAC     = 20;
	localparam int ROOT_W    = IFRAC;
	localparam int SQ_W      = 2 * IFRAC;
	localparam int CB_W      = 3 * IFRAC;
	localparam int E_W       = IFRAC + 1;
	localparam int P_W       = 2 * IFRAC + 2;
	localparam int MAG_W     = P_W;

	// Divider: integer bits INT_BITS..0 plus FRAC_BITS+1 fraction bits
	localparam int Q_W       = INT_BITS + FRAC_BITS + 2;
	localparam int REM_W     = MAG_W + FRAC_BITS + 1;
	localparam int DS_W      = MAG_W + Q_W;
	localparam int CW        = INT_BITS + FRAC_BITS + 1;

	localparam int ROOT_IDX_W = $clog2(ROOT_W);
	localparam int DIV_IDX_W  = $clog2(Q_W);

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	// Partial roots of one point: square root and cube root with their powers
	typedef struct packed {
		logic [ROOT_W-1:0] r2;
		logic [SQ_W-1:0]   s2;
		logic [ROOT_W-1:0] r3;
		logic [SQ_W-1:0]   q3;
		logic [CB_W-1:0]   c3;
	} root_lane_t;

	typedef struct packed {
		logic [IN_W-1:0] b1;
		logic [IN_W-1:0] y1;
		logic [IN_W-1:0] b2;
		logic [IN_W-1:0] y2;
		root_lane_t      l1;
		root_lane_t      l2;
	} root_stage_t;

	// One quotient in flight through the divider row
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [Q_W-1:0]   m;
		logic             neg;
		logic             sat;
	} div_lane_t;

	typedef struct packed {
		div_lane_t        a0;
		div_lane_t        a1;
		logic [MAG_W-1:0] d;
		logic             zero;
	} div_stage_t;

endpackage
`default_nettype wire

// ----- rtl/rcs_root_cell.sv -----
// One cell of the root row: decides one bit of both roots for both points.
// Depends on rcs_pkg for the stage type and widths.
`default_nettype none
module rcs_root_cell import rcs_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [ROOT_IDX_W-1:0] bit_idx,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire root_stage_t           in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output root_stage_t                out_data
);

	logic        valid_q;
	root_stage_t data_q;
	root_stage_t next_data;

	// Try bit k on both roots; powers of the trial value are built by shift and add
	function automatic root_lane_t step(root_lane_t l, logic [IN_W-1:0] b,
			logic [ROOT_IDX_W-1:0] k);
		logic [SQ_W+1:0] x2;
		logic [SQ_W+1:0] t2;
		logic [SQ_W+1:0] tq;
		logic [CB_W+1:0] x3;
		logic [CB_W+1:0] t3;
		logic [CB_W+1:0] qk;
		logic [CB_W+1:0] rk;
		root_lane_t      o;
		o  = l;
		x2 = (SQ_W+2)'(b) << (2 * IFRAC - IN_W);
		x3 = (CB_W+2)'(b) << (3 * IFRAC - IN_W);
		t2 = (SQ_W+2)'(l.s2) + ((SQ_W+2)'(l.r2) << (k + 1)) + ((SQ_W+2)'(1) << (2 * k));
		if (t2 <= x2) begin
			o.r2 = l.r2 | (ROOT_W'(1) << k);
			o.s2 = t2[SQ_W-1:0];
		end
		tq = (SQ_W+2)'(l.q3) + ((SQ_W+2)'(l.r3) << (k + 1)) + ((SQ_W+2)'(1) << (2 * k));
		qk = (CB_W+2)'(l.q3) << k;
		rk = (CB_W+2)'(l.r3) << (2 * k);
		t3 = (CB_W+2)'(l.c3) + qk + (qk << 1) + rk + (rk << 1) +
			((CB_W+2)'(1) << (3 * k));
		if (t3 <= x3) begin
			o.r3 = l.r3 | (ROOT_W'(1) << k);
			o.q3 = tq[SQ_W-1:0];
			o.c3 = t3[CB_W-1:0];
		end
		return o;
	endfunction

	always_comb begin
		next_data    = in_data;
		next_data.l1 = step(in_data.l1, in_data.b1, bit_idx);
		next_data.l2 = step(in_data.l2, in_data.b2, bit_idx);
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// Cell occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= next_data;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/rcs_div_cell.sv -----
// One cell of the divider row: restoring step for one quotient bit of both lanes.
// Depends on rcs_pkg for the stage type and widths.
`default_nettype none
module rcs_div_cell import rcs_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [DIV_IDX_W-1:0] bit_idx,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire div_stage_t           in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output div_stage_t                out_data
);

	logic       valid_q;
	div_stage_t data_q;
	div_stage_t next_data;

	// Subtract the divisor at weight j when it fits
	function automatic div_lane_t step(div_lane_t l, logic [MAG_W-1:0] d,
			logic [DIV_IDX_W-1:0] j);
		logic [DS_W-1:0] dsh;
		div_lane_t       o;
		o   = l;
		dsh = DS_W'(d) << j;
		if (DS_W'(l.rem) >= dsh) begin
			o.rem  = l.rem - dsh[REM_W-1:0];
			o.m[j] = 1'b1;
		end
		return o;
	endfunction

	always_comb begin
		next_data    = in_data;
		next_data.a0 = step(in_data.a0, in_data.d, bit_idx);
		next_data.a1 = step(in_data.a1, in_data.d, bit_idx);
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= next_data;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/root_curve_three_coeff_solve.sv -----
// Top level of the root-curve coefficient solver: root row, products, divider row.
// Depends on rcs_pkg, rcs_root_cell and rcs_div_cell.
//
// Usage:
//   Input channel: point1_x/point1_y/point2_x/point2_y with in_valid/in_stall.
//   A transfer happens on a rising edge with in_valid high and in_stall low.
//   Output channel: coef_cbrt/coef_sqrt/coef_linear/status with
//   out_valid/out_stall, same rule; one result per input item, in order.
//   Path from input transfer to out_valid: 20 root cells, four arithmetic
//   stages, 25 divider cells for the Q_W quotient bits and one output
//   register, 50 registers in line, the first loaded at the transfer.
//   Throughput: one item per cycle while out_stall is low; each cell
//   handles one root bit or one quotient bit.
//   Every cell has its own valid bit; a stalled receiver fills the empty
//   cells first, and in_stall rises only when the row back to the input is
//   full. Reset clears all valid bits; the block then accepts at once.
//   A zero divisor gives zero coefficients with status 1; clamping gives 2.
`default_nettype none
module root_curve_three_coeff_solve import rcs_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [IN_W-1:0]          point1_x,
	input  wire logic [IN_W-1:0]          point1_y,
	input  wire logic [IN_W-1:0]          point2_x,
	input  wire logic [IN_W-1:0]          point2_y,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [COEF_W-1:0]      coef_cbrt,
	output logic signed [COEF_W-1:0]      coef_sqrt,
	output logic signed [COEF_W-1:0]      coef_linear,
	output logic [1:0]                    status
);

	localparam logic signed [CW+1:0] ONE_Q = (CW+2)'(1) << FRAC_BITS;
	localparam logic signed [CW-1:0] HI_Q  = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] LO_Q  = {1'b1, {(CW-1){1'b0}}};

	// Root row
	root_stage_t rc_data  [ROOT_W+1];
	logic        rc_valid [ROOT_W+1];
	logic        rc_ready [ROOT_W+1];

	assign rc_data[0]  = {point1_x, point1_y, point2_x, point2_y,
		root_lane_t'('0), root_lane_t'('0)};
	assign rc_valid[0] = in_valid;
	assign in_stall    = !rc_ready[0];

	for (genvar i = 0; i < ROOT_W; i++) begin : g_root
		rcs_root_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.bit_idx   (ROOT_IDX_W'(ROOT_W - 1 - i)),
			.in_valid  (rc_valid[i]),
			.in_ready  (rc_ready[i]),
			.in_data   (rc_data[i]),
			.out_valid (rc_valid[i+1]),
			.out_ready (rc_ready[i+1]),
			.out_data  (rc_data[i+1])
		);
	end

	// Stage 1: differences from b and the six products
	logic                    v_s1, v_s2, v_s3, v_s4;
	logic                    rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic signed [P_W-1:0]   pa_s1, pb_s1, n1a_s1, n1b_s1, n0a_s1, n0b_s1;
	logic [ROOT_W-1:0]       bb1, bb2, d2a, d3a, d2b, d3b;
	logic signed [E_W-1:0]   e1, e2, sd2a, sd3a, sd2b, sd3b;
	root_stage_t             rl;

	assign rl   = rc_data[ROOT_W];
	assign bb1  = ROOT_W'(rl.b1) << (IFRAC - IN_W);
	assign bb2  = ROOT_W'(rl.b2) << (IFRAC - IN_W);
	assign e1   = signed'(E_W'(rl.y1) << (IFRAC - IN_W)) - signed'(E_W'(bb1));
	assign e2   = signed'(E_W'(rl.y2) << (IFRAC - IN_W)) - signed'(E_W'(bb2));
	assign d2a  = rl.l1.r2 - bb1;
	assign d3a  = rl.l1.r3 - bb1;
	assign d2b  = rl.l2.r2 - bb2;
	assign d3b  = rl.l2.r3 - bb2;
	assign sd2a = signed'({1'b0, d2a});
	assign sd3a = signed'({1'b0, d3a});
	assign sd2b = signed'({1'b0, d2b});
	assign sd3b = signed'({1'b0, d3b});

	assign rc_ready[ROOT_W] = rdy_s1;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s3 = !v_s3 || rdy_s4;

	always_ff @(posedge clk) begin
		if (rdy_s1 && rc_valid[ROOT_W]) begin
			pa_s1  <= P_W'(sd2b) * P_W'(sd3a);
			pb_s1  <= P_W'(sd2a) * P_W'(sd3b);
			n1a_s1 <= P_W'(e2) * P_W'(sd3a);
			n1b_s1 <= P_W'(e1) * P_W'(sd3b);
			n0a_s1 <= P_W'(e1) * P_W'(sd2b);
			n0b_s1 <= P_W'(e2) * P_W'(sd2a);
		end
	end

	// Stage 2: divisor and the two numerators
	logic signed [P_W-1:0] den_s2, n0_s2, n1_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			den_s2 <= pa_s1 - pb_s1;
			n1_s2  <= n1a_s1 - n1b_s1;
			n0_s2  <= n0a_s1 - n0b_s1;
		end
	end

	// Stage 3: magnitudes and quotient signs
	logic [MAG_W-1:0] d_s3, m0_s3, m1_s3;
	logic             neg0_s3, neg1_s3, zero_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			d_s3    <= den_s2[P_W-1] ? MAG_W'(-den_s2) : MAG_W'(den_s2);
			m0_s3   <= n0_s2[P_W-1] ? MAG_W'(-n0_s2) : MAG_W'(n0_s2);
			m1_s3   <= n1_s2[P_W-1] ? MAG_W'(-n1_s2) : MAG_W'(n1_s2);
			neg0_s3 <= n0_s2[P_W-1] ^ den_s2[P_W-1];
			neg1_s3 <= n1_s2[P_W-1] ^ den_s2[P_W-1];
			zero_s3 <= (den_s2 == '0);
		end
	end

	// Stage 4: overflow check and scaled dividend
	div_stage_t                dc_data  [Q_W+1];
	logic                      dc_valid [Q_W+1];
	logic                      dc_ready [Q_W+1];
	logic [MAG_W+INT_BITS:0]   lim;
	div_stage_t                dv_s4;

	assign lim = ((MAG_W+INT_BITS+1)'(d_s3) << INT_BITS) + (MAG_W+INT_BITS+1)'(d_s3);

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			dv_s4.a0.rem <= REM_W'(m0_s3) << (FRAC_BITS + 1);
			dv_s4.a1.rem <= REM_W'(m1_s3) << (FRAC_BITS + 1);
			dv_s4.a0.m   <= '0;
			dv_s4.a1.m   <= '0;
			dv_s4.a0.neg <= neg0_s3;
			dv_s4.a1.neg <= neg1_s3;
			dv_s4.a0.sat <= ((MAG_W+INT_BITS+1)'(m0_s3) >= lim);
			dv_s4.a1.sat <= ((MAG_W+INT_BITS+1)'(m1_s3) >= lim);
			dv_s4.d      <= d_s3;
			dv_s4.zero   <= zero_s3;
		end
	end

	assign dc_data[0]  = dv_s4;
	assign rdy_s4      = !v_s4 || dc_ready[0];
	assign dc_valid[0] = v_s4;

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= rc_valid[ROOT_W];
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// Divider row
	for (genvar i = 0; i < Q_W; i++) begin : g_div
		rcs_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.bit_idx   (DIV_IDX_W'(Q_W - 1 - i)),
			.in_valid  (dc_valid[i]),
			.in_ready  (dc_ready[i]),
			.in_data   (dc_data[i]),
			.out_valid (dc_valid[i+1]),
			.out_ready (dc_ready[i+1]),
			.out_data  (dc_data[i+1])
		);
	end

	// Round half away from zero, apply sign, clamp; top bit flags a clamp
	function automatic logic [CW:0] finish(div_lane_t l);
		logic [Q_W-1:0]        mr;
		logic signed [Q_W:0]   v;
		logic signed [CW-1:0]  val;
		logic                  s;
		mr = Q_W'((l.m + Q_W'(1)) >> 1);
		v  = l.neg ? -signed'({1'b0, mr}) : signed'({1'b0, mr});
		s  = 1'b0;
		if (l.sat) begin
			s   = 1'b1;
			val = l.neg ? LO_Q : HI_Q;
		end else if (v > (Q_W+1)'(HI_Q)) begin
			s   = 1'b1;
			val = HI_Q;
		end else if (v < (Q_W+1)'(LO_Q)) begin
			s   = 1'b1;
			val = LO_Q;
		end else begin
			val = CW'(v);
		end
		return {s, val};
	endfunction

	// Final coefficients and status
	div_stage_t            dl;
	logic [CW:0]           f0, f1;
	logic signed [CW-1:0]  c0, c1, c2;
	logic signed [CW+1:0]  t2;
	logic                  sat2;
	status_t               st;

	assign dl = dc_data[Q_W];

	always_comb begin
		f0   = finish(dl.a0);
		f1   = finish(dl.a1);
		c0   = signed'(f0[CW-1:0]);
		c1   = signed'(f1[CW-1:0]);
		t2   = ONE_Q - (CW+2)'(c0) - (CW+2)'(c1);
		sat2 = 1'b0;
		if (t2 > (CW+2)'(HI_Q)) begin
			c2   = HI_Q;
			sat2 = 1'b1;
		end else if (t2 < (CW+2)'(LO_Q)) begin
			c2   = LO_Q;
			sat2 = 1'b1;
		end else begin
			c2 = CW'(t2);
		end
		st = (f0[CW] || f1[CW] || sat2) ? ST_SAT : ST_OK;
		if (dl.zero) begin
			c0 = '0;
			c1 = '0;
			c2 = '0;
			st = ST_ZERO;
		end
	end

	// Output register
	logic                     out_v_q;
	logic signed [COEF_W-1:0] cbrt_q, sqrt_q, lin_q;
	status_t                  status_q;

	assign dc_ready[Q_W] = !out_v_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (dc_ready[Q_W]) begin
			out_v_q <= dc_valid[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (dc_ready[Q_W] && dc_valid[Q_W]) begin
			cbrt_q   <= COEF_W'(64'(c0));
			sqrt_q   <= COEF_W'(64'(c1));
			lin_q    <= COEF_W'(64'(c2));
			status_q <= st;
		end
	end

	assign out_valid   = out_v_q;
	assign coef_cbrt   = cbrt_q;
	assign coef_sqrt   = sqrt_q;
	assign coef_linear = lin_q;
	assign status      = status_q;

	// Checks
	a_zero_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_ZERO) |->
		(coef_cbrt == '0 && coef_sqrt == '0 && coef_linear == '0))
		else $error("zero-divisor result carries nonzero coefficients");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!rc_valid[1] |-> !in_stall)
		else $error("input stalled with the first cell empty");

	a_div_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(dc_valid[Q_W] && dc_ready[Q_W]) |=> out_valid)
		else $error("transfer from the divider row lost at the output");

endmodule
`default_nettype wire
